### rtl/polygon_area_perimeter_bbox_defines.svh
// ----------------------------------------------------------------------------
// polygon_area_perimeter_bbox_defines.svh
// Assertion macros for the polygon area / perimeter / bounding box block.
// Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef POLYGON_AREA_PERIMETER_BBOX_DEFINES_SVH
`define POLYGON_AREA_PERIMETER_BBOX_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PAPB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("papb assertion failed");

// next-cycle implication
`define PAPB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("papb assertion failed");

`else

`define PAPB_ASSERT_IMP(label, clk, rst, ante, cons)
`define PAPB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/papb_pkg.sv
// ----------------------------------------------------------------------------
// papb_pkg
// Widths, limits and types shared by the polygon block and its interfaces.
// ----------------------------------------------------------------------------
package papb_pkg;

  localparam int COORD_BITS   = 20;
  localparam int MAX_VERTICES = 4096;
  localparam int MIN_VERTICES = 2;

  localparam int DIFF_W  = COORD_BITS + 1;       // coordinate difference
  localparam int HI_W    = DIFF_W + 1;           // multiplier upper half
  localparam int PROD_W  = 2 * DIFF_W;           // full product
  localparam int ROOT_W  = DIFF_W;               // edge length
  localparam int REM_W   = ROOT_W + 2;           // root remainder
  localparam int TRY_W   = ROOT_W + 4;           // root trial compare
  localparam int CROSS_W = 54;
  localparam int LEN_W   = 34;
  localparam int HALF_W  = LEN_W - 1;
  localparam int AREA_W  = 52;
  localparam int COUNT_W = $clog2(MAX_VERTICES + 1);
  localparam int STEP_W  = $clog2(AREA_W);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic        [LEN_W-1:0]      len_t;
  typedef logic        [HALF_W-1:0]     half_t;
  typedef logic        [AREA_W-1:0]     area_t;
  typedef logic        [COUNT_W-1:0]    count_t;

  localparam coord_t COORD_POS = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_NEG = {1'b1, {(COORD_BITS-1){1'b0}}};

endpackage

### rtl/papb_if.sv
// ----------------------------------------------------------------------------
// papb_if
// Valid/ready channels of the polygon block: vertex beats in, result beats out.
// ----------------------------------------------------------------------------
interface papb_vertex_if;
  import papb_pkg::*;

  logic   valid;
  logic   ready;
  coord_t x;
  coord_t y;
  logic   last_vertex;

  modport source (output valid, x, y, last_vertex, input ready);
  modport sink   (input valid, x, y, last_vertex, output ready);
endinterface

interface papb_result_if;
  import papb_pkg::*;

  logic   valid;
  logic   ready;
  area_t  area;
  logic   clockwise;
  len_t   perimeter;
  half_t  half_perimeter;
  len_t   mean_width;
  coord_t box_x_low;
  coord_t box_x_high;
  coord_t box_y_low;
  coord_t box_y_high;
  count_t vertex_total;
  logic   degenerate;

  modport source (output valid, area, clockwise, perimeter, half_perimeter, mean_width,
                  box_x_low, box_x_high, box_y_low, box_y_high, vertex_total,
                  degenerate, input ready);
  modport sink   (input valid, area, clockwise, perimeter, half_perimeter, mean_width,
                  box_x_low, box_x_high, box_y_low, box_y_high, vertex_total,
                  degenerate, output ready);
endinterface

### rtl/polygon_area_perimeter_bbox.sv
// ----------------------------------------------------------------------------
// polygon_area_perimeter_bbox
// Streams polygon vertices and reports area, orientation, perimeter, mean
// width and bounding box when the last vertex closes the polygon.
// ----------------------------------------------------------------------------
// Each edge is worked out bit-serially: four 21-bit shift-add multipliers
// (two cross products, two squared differences) run first, then a
// restoring square root follows, one root bit a cycle, and the S_ACC and
// S_LEN states fold the cross term and the edge length into their sums. A
// vertex that opens an edge therefore holds ready low until S_LEN is done,
// so the next vertex is not taken before its edge is through; the first
// vertex of a polygon opens no edge unless it is also the last. The last
// vertex also runs the closing edge, a result setup step (S_FIN) and a
// restoring divide for the mean width (the divide is skipped for a degenerate
// polygon). The result sits in an output register, so the next polygon's
// vertices are taken while a result waits downstream.
// ----------------------------------------------------------------------------
`include "polygon_area_perimeter_bbox_defines.svh"

module polygon_area_perimeter_bbox (
  input  logic            clk,
  input  logic            rst,
  papb_vertex_if.sink     vertex,
  papb_result_if.source   result
);
  import papb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_LEN  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(DIFF_W - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(AREA_W - 1);

  // control
  logic [2:0]        state;
  logic [STEP_W-1:0] step;
  logic              is_close;    // edge in flight is the closing edge
  logic              close_pend;  // closing edge follows the current one

  // polygon state
  coord_t                     first_x, first_y, prev_x, prev_y, cur_x, cur_y;
  logic signed [CROSS_W-1:0]  cross_sum;
  len_t                       length_sum;
  coord_t                     min_x_seen, max_x_seen, min_y_seen, max_y_seen;
  count_t                     count_seen;

  // serial multipliers
  diff_t             mul_a   [4];
  logic [HI_W-1:0]   mul_hi  [4];
  logic [DIFF_W-1:0] mul_lo  [4];
  logic [HI_W-1:0]   mul_add [4];
  logic [HI_W-1:0]   mul_sum [4];
  logic [PROD_W-1:0] prod    [4];
  diff_t             op_a    [4];
  diff_t             op_b    [4];

  // square root
  logic [PROD_W-1:0] rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [TRY_W-1:0]  sq_rem_t, sq_trial, sq_diff;
  logic              sq_ge;

  // result setup and divide
  area_t             area_r;
  logic              cw_r;
  len_t              perim_r;
  half_t             half_r;
  logic              degen_r;
  area_t             dq;
  half_t             drem;
  logic [HALF_W:0]   dv_rt, dv_diff;
  logic              dv_ge;

  // combinational helpers
  logic              accept, mul_start, out_load;
  coord_t            ea_x, ea_y, eb_x, eb_y;
  diff_t             dx, dy;
  logic [CROSS_W:0]  cs_full;
  logic [CROSS_W-1:0] cs_sat;
  logic [LEN_W:0]    ls_full;
  len_t              ls_sat;
  logic [CROSS_W-1:0] mag;
  area_t             area_sat;
  half_t             half_w;
  logic              degen, cw;
  len_t              width_sat;

  assign vertex.ready = (state == S_IDLE);
  assign accept       = vertex.valid && vertex.ready;
  assign mul_start    = (accept && (count_seen != '0 || vertex.last_vertex)) ||
                        (state == S_LEN && close_pend);
  assign out_load     = (state == S_OUT) && (!result.valid || result.ready);

  // edge endpoints: prev->new on accept, self edge for a lone vertex, closing edge in S_LEN
  always_comb begin
    if (state == S_LEN) begin
      ea_x = cur_x;    ea_y = cur_y;    eb_x = first_x;  eb_y = first_y;
    end else if (count_seen != '0) begin
      ea_x = prev_x;   ea_y = prev_y;   eb_x = vertex.x; eb_y = vertex.y;
    end else begin
      ea_x = vertex.x; ea_y = vertex.y; eb_x = vertex.x; eb_y = vertex.y;
    end
  end

  always_comb begin
    dx = {ea_x[COORD_BITS-1], ea_x} - {eb_x[COORD_BITS-1], eb_x};
    dy = {ea_y[COORD_BITS-1], ea_y} - {eb_y[COORD_BITS-1], eb_y};
    op_a[0] = {ea_x[COORD_BITS-1], ea_x};
    op_b[0] = {eb_y[COORD_BITS-1], eb_y};
    op_a[1] = {ea_y[COORD_BITS-1], ea_y};
    op_b[1] = {eb_x[COORD_BITS-1], eb_x};
    op_a[2] = dx;
    op_b[2] = dx;
    op_a[3] = dy;
    op_b[3] = dy;
  end

  // one multiplier bit per cycle; the sign bit of the multiplier subtracts
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (!mul_lo[i][0]) begin
        mul_add[i] = '0;
      end else if (step == '0) begin
        mul_add[i] = ~{mul_a[i][DIFF_W-1], mul_a[i]} + HI_W'(1);
      end else begin
        mul_add[i] = {mul_a[i][DIFF_W-1], mul_a[i]};
      end
      mul_sum[i] = mul_hi[i] + mul_add[i];
      prod[i]    = {mul_hi[i][DIFF_W-1:0], mul_lo[i]};
    end
  end

  // cross term into the shoelace sum, saturating
  always_comb begin
    cs_full = {cross_sum[CROSS_W-1], cross_sum}
            + {{(CROSS_W+1-PROD_W){prod[0][PROD_W-1]}}, prod[0]}
            - {{(CROSS_W+1-PROD_W){prod[1][PROD_W-1]}}, prod[1]};
    if (cs_full[CROSS_W] != cs_full[CROSS_W-1]) begin
      cs_sat = cs_full[CROSS_W] ? {1'b1, {(CROSS_W-1){1'b0}}} : {1'b0, {(CROSS_W-1){1'b1}}};
    end else begin
      cs_sat = cs_full[CROSS_W-1:0];
    end
  end

  always_comb begin
    sq_rem_t = {rem, rad[PROD_W-1 -: 2]};
    sq_trial = {2'b00, root, 2'b01};
    sq_ge    = (sq_rem_t >= sq_trial);
    sq_diff  = sq_rem_t - sq_trial;
  end

  always_comb begin
    ls_full = {1'b0, length_sum} + {{(LEN_W+1-ROOT_W){1'b0}}, root};
    ls_sat  = ls_full[LEN_W] ? {LEN_W{1'b1}} : ls_full[LEN_W-1:0];
  end

  always_comb begin
    mag      = cross_sum[CROSS_W-1] ? (~cross_sum + CROSS_W'(1)) : cross_sum;
    area_sat = mag[CROSS_W-1] ? {AREA_W{1'b1}} : mag[AREA_W:1];
    half_w   = length_sum[LEN_W-1:1];
    degen    = (count_seen < COUNT_W'(MIN_VERTICES)) || (half_w == '0);
    cw       = !cross_sum[CROSS_W-1] && (cross_sum != '0);
  end

  always_comb begin
    dv_rt     = {drem, dq[AREA_W-1]};
    dv_ge     = (dv_rt >= {1'b0, half_r});
    dv_diff   = dv_rt - {1'b0, half_r};
    width_sat = (dq[AREA_W-1:LEN_W] != '0) ? {LEN_W{1'b1}} : dq[LEN_W-1:0];
  end

  // control and polygon state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      is_close   <= 1'b0;
      close_pend <= 1'b0;
      cross_sum  <= '0;
      length_sum <= '0;
      min_x_seen <= COORD_POS;
      max_x_seen <= COORD_NEG;
      min_y_seen <= COORD_POS;
      max_y_seen <= COORD_NEG;
      count_seen <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (vertex.x < min_x_seen) min_x_seen <= vertex.x;
            if (vertex.x > max_x_seen) max_x_seen <= vertex.x;
            if (vertex.y < min_y_seen) min_y_seen <= vertex.y;
            if (vertex.y > max_y_seen) max_y_seen <= vertex.y;
            if (count_seen < COUNT_W'(MAX_VERTICES)) count_seen <= count_seen + COUNT_W'(1);
            is_close   <= (count_seen == '0) && vertex.last_vertex;
            close_pend <= (count_seen != '0) && vertex.last_vertex;
            if (mul_start) begin
              state <= S_MUL;
              step  <= MUL_LAST;
            end
          end
        end
        S_MUL: begin
          if (step == '0) state <= S_ACC;
          else            step  <= step - STEP_W'(1);
        end
        S_ACC: begin
          cross_sum <= cs_sat;
          state     <= S_SQRT;
          step      <= ROOT_LAST;
        end
        S_SQRT: begin
          if (step == '0) state <= S_LEN;
          else            step  <= step - STEP_W'(1);
        end
        S_LEN: begin
          length_sum <= ls_sat;
          if (close_pend) begin
            close_pend <= 1'b0;
            is_close   <= 1'b1;
            state      <= S_MUL;
            step       <= MUL_LAST;
          end else if (is_close) begin
            state <= S_FIN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FIN: begin
          state <= degen ? S_OUT : S_DIV;
          step  <= DIV_LAST;
        end
        S_DIV: begin
          if (step == '0) state <= S_OUT;
          else            step  <= step - STEP_W'(1);
        end
        S_OUT: begin
          if (out_load) begin
            cross_sum  <= '0;
            length_sum <= '0;
            min_x_seen <= COORD_POS;
            max_x_seen <= COORD_NEG;
            min_y_seen <= COORD_POS;
            max_y_seen <= COORD_NEG;
            count_seen <= '0;
            is_close   <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x  <= vertex.x;
      cur_y  <= vertex.y;
      prev_x <= vertex.x;
      prev_y <= vertex.y;
      if (count_seen == '0) begin
        first_x <= vertex.x;
        first_y <= vertex.y;
      end
    end

    if (mul_start) begin
      for (int i = 0; i < 4; i++) begin
        mul_a[i]  <= op_a[i];
        mul_lo[i] <= op_b[i];
        mul_hi[i] <= '0;
      end
    end else if (state == S_MUL) begin
      for (int i = 0; i < 4; i++) begin
        mul_hi[i] <= {mul_sum[i][HI_W-1], mul_sum[i][HI_W-1:1]};
        mul_lo[i] <= {mul_sum[i][0], mul_lo[i][DIFF_W-1:1]};
      end
    end

    case (state)
      S_ACC: begin
        rad  <= prod[2] + prod[3];
        rem  <= '0;
        root <= '0;
      end
      S_SQRT: begin
        rem  <= sq_ge ? sq_diff[REM_W-1:0] : sq_rem_t[REM_W-1:0];
        root <= {root[ROOT_W-2:0], sq_ge};
        rad  <= {rad[PROD_W-3:0], 2'b00};
      end
      S_FIN: begin
        degen_r <= degen;
        cw_r    <= !degen && cw;
        area_r  <= degen ? '0 : area_sat;
        perim_r <= degen ? '0 : length_sum;
        half_r  <= degen ? '0 : half_w;
        dq      <= area_sat;
        drem    <= '0;
      end
      S_DIV: begin
        drem <= dv_ge ? dv_diff[HALF_W-1:0] : dv_rt[HALF_W-1:0];
        dq   <= {dq[AREA_W-2:0], dv_ge};
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.area           <= area_r;
      result.clockwise      <= cw_r;
      result.perimeter      <= perim_r;
      result.half_perimeter <= half_r;
      result.mean_width     <= degen_r ? '0 : width_sat;
      result.box_x_low      <= min_x_seen;
      result.box_x_high     <= max_x_seen;
      result.box_y_low      <= min_y_seen;
      result.box_y_high     <= max_y_seen;
      result.vertex_total   <= count_seen;
      result.degenerate     <= degen_r;
    end
  end

  // no new vertex while a polygon is being closed
  `PAPB_ASSERT_IMP(a_close_blocks_input, clk, rst, is_close || close_pend, !vertex.ready)
  // once a vertex is in, the box is well ordered
  `PAPB_ASSERT_IMP(a_box_ordered, clk, rst, count_seen != '0, (min_x_seen <= max_x_seen) && (min_y_seen <= max_y_seen))
  // divider remainder stays below the divisor
  `PAPB_ASSERT_IMP(a_div_rem_bound, clk, rst, state == S_DIV, (half_r != '0) && (drem < half_r))
  // loading a result starts a fresh polygon
  `PAPB_ASSERT_NEXT(a_out_clears, clk, rst, out_load, result.valid && (count_seen == '0) && (state == S_IDLE))

endmodule
